[design/pth_sensor_compensation_unit_defines.svh]
// Assertion macros shared by the compensation unit RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef PTH_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define PSCU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pscu assertion failed");
// Check that a condition never holds outside reset
`define PSCU_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("pscu forbidden condition seen");
`else
`define PSCU_ASSERT(lbl, prop)
`define PSCU_ASSERT_NEVER(lbl, cond)
`endif

`endif

[design/pscu_pkg.sv]
// Types, constants and the compensation microprogram of the compensation unit.
// Used by pscu_front, pscu_engine and pth_sensor_compensation_unit.
package pscu_pkg;

    // Queue between front and engine
    localparam int QUEUE_DEPTH_DEF = 4;

    // Scratch memory and sequencer sizes
    localparam int TMP_AW     = 4;
    localparam int PC_W       = 7;
    localparam int UOP_COUNT  = 73;
    localparam int MUL_CHUNKS = 4;
    localparam int DIV_STEPS  = 64;

    // Microprogram steps whose results feed the output fields
    localparam logic [PC_W-1:0] UPC_TEMP = 7'd14;
    localparam logic [PC_W-1:0] UPC_PRES = 7'd46;
    localparam logic [PC_W-1:0] UPC_HUM  = 7'd72;

    // Configuration register indexes
    localparam logic [2:0] REG_TP_LOW    = 3'd0;
    localparam logic [2:0] REG_TP_MID    = 3'd1;
    localparam logic [2:0] REG_TP_HIGH   = 3'd2;
    localparam logic [2:0] REG_HUM_FIRST = 3'd3;
    localparam logic [2:0] REG_HUM_REST  = 3'd4;

    // Clamp limits
    localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
    localparam logic signed [31:0] HUM_MAX  = 32'sd419430400;

    typedef struct packed {
        logic [63:0] tp_low;
        logic [63:0] tp_mid;
        logic [63:0] tp_high;
        logic [7:0]  hum_first;
        logic [55:0] hum_rest;
    } pscu_calib_t;

    typedef struct packed {
        logic [15:0] raw_humidity;
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } pscu_item_t;

    typedef struct packed {
        logic       valid;
        pscu_item_t item;
    } pscu_deq_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SRA,
        OP_SHL,
        OP_DIV
    } uop_kind_t;

    // Fixed operands: raw inputs, coefficients and constants
    typedef enum logic [4:0] {
        FX_AT, FX_AP, FX_AH,
        FX_T1, FX_T2, FX_T3,
        FX_P1, FX_P2, FX_P3, FX_P4, FX_P5, FX_P6, FX_P7, FX_P8, FX_P9,
        FX_H1, FX_H2, FX_H3, FX_H4, FX_H5, FX_H6,
        FX_C5, FX_C128, FX_C128000, FX_C2P20, FX_C3125, FX_C2P47,
        FX_C76800, FX_C16384, FX_C32768, FX_C2097152, FX_C8192
    } fx_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        uop_kind_t             kind;
        logic                  w32;
        logic [TMP_AW-1:0]     dst;
        logic                  a_fx;
        logic [4:0]            a_sel;
        logic                  b_fx;
        logic [4:0]            b_sel;
        logic [5:0]            sh;
    } pscu_uop_t;

    function automatic pscu_uop_t mk_op(uop_kind_t k, logic w, int d, logic afx, int a,
                                        logic bfx, int b, int s);
        pscu_uop_t u;
        u.kind  = k;
        u.w32   = w;
        u.dst   = TMP_AW'(d);
        u.a_fx  = afx;
        u.a_sel = 5'(a);
        u.b_fx  = bfx;
        u.b_sel = 5'(b);
        u.sh    = 6'(s);
        return u;
    endfunction

    // temp op temp
    function automatic pscu_uop_t rr(uop_kind_t k, logic w, int d, int a, int b);
        return mk_op(k, w, d, 1'b0, a, 1'b0, b, 0);
    endfunction

    // temp op fixed
    function automatic pscu_uop_t rf(uop_kind_t k, logic w, int d, int a, fx_src_t f);
        return mk_op(k, w, d, 1'b0, a, 1'b1, int'(f), 0);
    endfunction

    // fixed op temp
    function automatic pscu_uop_t fr(uop_kind_t k, logic w, int d, fx_src_t f, int b);
        return mk_op(k, w, d, 1'b1, int'(f), 1'b0, b, 0);
    endfunction

    // fixed op fixed
    function automatic pscu_uop_t ff(uop_kind_t k, logic w, int d, fx_src_t f, fx_src_t g);
        return mk_op(k, w, d, 1'b1, int'(f), 1'b1, int'(g), 0);
    endfunction

    // shift of a temp
    function automatic pscu_uop_t shr(uop_kind_t k, logic w, int d, int a, int s);
        return mk_op(k, w, d, 1'b0, a, 1'b0, 0, s);
    endfunction

    // shift of a fixed operand
    function automatic pscu_uop_t shf(uop_kind_t k, logic w, int d, fx_src_t f, int s);
        return mk_op(k, w, d, 1'b1, int'(f), 1'b0, 0, s);
    endfunction

    // Compensation microprogram; w32 steps wrap to 32 bits and sign-extend
    function automatic pscu_uop_t uop_rom(logic [PC_W-1:0] pc);
        pscu_uop_t u;
        case (pc)
            // temperature path
            7'd0:  u = shf(OP_SRA, 1'b1, 0, FX_AT, 3);
            7'd1:  u = shf(OP_SHL, 1'b1, 1, FX_T1, 1);
            7'd2:  u = rr(OP_SUB, 1'b1, 0, 0, 1);
            7'd3:  u = rf(OP_MUL, 1'b1, 0, 0, FX_T2);
            7'd4:  u = shr(OP_SRA, 1'b1, 0, 0, 11);
            7'd5:  u = shf(OP_SRA, 1'b1, 1, FX_AT, 4);
            7'd6:  u = rf(OP_SUB, 1'b1, 1, 1, FX_T1);
            7'd7:  u = rr(OP_MUL, 1'b1, 1, 1, 1);
            7'd8:  u = shr(OP_SRA, 1'b1, 1, 1, 12);
            7'd9:  u = rf(OP_MUL, 1'b1, 1, 1, FX_T3);
            7'd10: u = shr(OP_SRA, 1'b1, 1, 1, 14);
            7'd11: u = rr(OP_ADD, 1'b1, 2, 0, 1);
            7'd12: u = rf(OP_MUL, 1'b1, 3, 2, FX_C5);
            7'd13: u = rf(OP_ADD, 1'b1, 3, 3, FX_C128);
            7'd14: u = shr(OP_SRA, 1'b1, 3, 3, 8);
            // pressure path
            7'd15: u = rf(OP_SUB, 1'b0, 4, 2, FX_C128000);
            7'd16: u = rr(OP_MUL, 1'b0, 5, 4, 4);
            7'd17: u = rf(OP_MUL, 1'b0, 6, 5, FX_P6);
            7'd18: u = rf(OP_MUL, 1'b0, 7, 4, FX_P5);
            7'd19: u = shr(OP_SHL, 1'b0, 7, 7, 17);
            7'd20: u = rr(OP_ADD, 1'b0, 6, 6, 7);
            7'd21: u = shf(OP_SHL, 1'b0, 7, FX_P4, 35);
            7'd22: u = rr(OP_ADD, 1'b0, 6, 6, 7);
            7'd23: u = rf(OP_MUL, 1'b0, 5, 5, FX_P3);
            7'd24: u = shr(OP_SRA, 1'b0, 5, 5, 8);
            7'd25: u = rf(OP_MUL, 1'b0, 7, 4, FX_P2);
            7'd26: u = shr(OP_SHL, 1'b0, 7, 7, 12);
            7'd27: u = rr(OP_ADD, 1'b0, 5, 5, 7);
            7'd28: u = rf(OP_ADD, 1'b0, 5, 5, FX_C2P47);
            7'd29: u = rf(OP_MUL, 1'b0, 5, 5, FX_P1);
            7'd30: u = shr(OP_SRA, 1'b0, 5, 5, 33);
            7'd31: u = ff(OP_SUB, 1'b0, 7, FX_C2P20, FX_AP);
            7'd32: u = shr(OP_SHL, 1'b0, 7, 7, 31);
            7'd33: u = rr(OP_SUB, 1'b0, 7, 7, 6);
            7'd34: u = rf(OP_MUL, 1'b0, 7, 7, FX_C3125);
            7'd35: u = rr(OP_DIV, 1'b0, 7, 7, 5);
            7'd36: u = shr(OP_SRA, 1'b0, 8, 7, 13);
            7'd37: u = fr(OP_MUL, 1'b0, 9, FX_P9, 8);
            7'd38: u = rr(OP_MUL, 1'b0, 9, 9, 8);
            7'd39: u = shr(OP_SRA, 1'b0, 9, 9, 25);
            7'd40: u = fr(OP_MUL, 1'b0, 10, FX_P8, 7);
            7'd41: u = shr(OP_SRA, 1'b0, 10, 10, 19);
            7'd42: u = rr(OP_ADD, 1'b0, 7, 7, 9);
            7'd43: u = rr(OP_ADD, 1'b0, 7, 7, 10);
            7'd44: u = shr(OP_SRA, 1'b0, 7, 7, 8);
            7'd45: u = shf(OP_SHL, 1'b0, 9, FX_P7, 4);
            7'd46: u = rr(OP_ADD, 1'b0, 7, 7, 9);
            // humidity path
            7'd47: u = rf(OP_SUB, 1'b1, 0, 2, FX_C76800);
            7'd48: u = shf(OP_SHL, 1'b1, 1, FX_AH, 14);
            7'd49: u = shf(OP_SHL, 1'b1, 4, FX_H4, 20);
            7'd50: u = rr(OP_SUB, 1'b1, 1, 1, 4);
            7'd51: u = fr(OP_MUL, 1'b1, 4, FX_H5, 0);
            7'd52: u = rr(OP_SUB, 1'b1, 1, 1, 4);
            7'd53: u = rf(OP_ADD, 1'b1, 1, 1, FX_C16384);
            7'd54: u = shr(OP_SRA, 1'b1, 1, 1, 15);
            7'd55: u = rf(OP_MUL, 1'b1, 4, 0, FX_H6);
            7'd56: u = shr(OP_SRA, 1'b1, 4, 4, 10);
            7'd57: u = rf(OP_MUL, 1'b1, 5, 0, FX_H3);
            7'd58: u = shr(OP_SRA, 1'b1, 5, 5, 11);
            7'd59: u = rf(OP_ADD, 1'b1, 5, 5, FX_C32768);
            7'd60: u = rr(OP_MUL, 1'b1, 4, 4, 5);
            7'd61: u = shr(OP_SRA, 1'b1, 4, 4, 10);
            7'd62: u = rf(OP_ADD, 1'b1, 4, 4, FX_C2097152);
            7'd63: u = rf(OP_MUL, 1'b1, 4, 4, FX_H2);
            7'd64: u = rf(OP_ADD, 1'b1, 4, 4, FX_C8192);
            7'd65: u = shr(OP_SRA, 1'b1, 4, 4, 14);
            7'd66: u = rr(OP_MUL, 1'b1, 1, 1, 4);
            7'd67: u = shr(OP_SRA, 1'b1, 4, 1, 15);
            7'd68: u = rr(OP_MUL, 1'b1, 4, 4, 4);
            7'd69: u = shr(OP_SRA, 1'b1, 4, 4, 7);
            7'd70: u = rf(OP_MUL, 1'b1, 4, 4, FX_H1);
            7'd71: u = shr(OP_SRA, 1'b1, 4, 4, 4);
            7'd72: u = rr(OP_SUB, 1'b1, 1, 1, 4);
            default: u = rr(OP_ADD, 1'b0, 15, 15, 15);
        endcase
        return u;
    endfunction

endpackage

[design/pscu_front.sv]
// Input side of the compensation unit: stream slave and sample queue.
// Depends on pscu_pkg and the shared assertion macros.
`include "pth_sensor_compensation_unit_defines.svh"

module pscu_front #(
    parameter int DEPTH = pscu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [55:0]        s_tdata,
    output pscu_pkg::pscu_deq_t deq,
    input  logic               deq_ready
);
    import pscu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pscu_item_t         q_mem [DEPTH];
    pscu_item_t         in_item;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push, pop;

    // Split the transfer into its fields
    always_comb
    begin
        in_item.raw_pressure    = s_tdata[19:0];
        in_item.raw_temperature = s_tdata[39:20];
        in_item.raw_humidity    = s_tdata[55:40];
    end

    assign s_tready = (cnt_reg != CNT_W'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = deq.valid && deq_ready;

    always_comb
    begin
        deq.valid = (cnt_reg != '0);
        deq.item  = q_mem[rd_ptr_reg];
    end

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store accepted samples
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    `PSCU_ASSERT_NEVER(a_cnt_bound, cnt_reg > CNT_W'(DEPTH))
    `PSCU_ASSERT(a_cnt_inc, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
    `PSCU_ASSERT(a_empty_ptrs, (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))

endmodule

[design/pscu_engine.sv]
// Compensation engine: microcoded sequencer over a scratch memory, a 64x16
// multiplier used over four 16-bit slices and a radix-2 divider. Depends on pscu_pkg.
`include "pth_sensor_compensation_unit_defines.svh"

module pscu_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pscu_pkg::pscu_calib_t calib,
    input  pscu_pkg::pscu_deq_t   deq,
    output logic                  deq_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] temperature_centi, [47:16] pressure_q24_8, [64:48] humidity_q22_10
    output logic [71:0]           m_tdata,
    // [0] pressure_divisor_zero
    output logic                  m_tuser
);
    import pscu_pkg::*;

    eng_state_t          state_reg, state_next;
    logic [PC_W-1:0]     pc_reg;
    pscu_uop_t           uop;

    logic [19:0]         ap_reg, at_reg;
    logic [15:0]         ah_reg;

    logic [63:0]         tmp_mem [2**TMP_AW];
    logic [63:0]         rda_reg, rdb_reg;
    logic [63:0]         opa, opb;

    logic [63:0]         alu_raw, alu_res;
    logic [1:0]          mk_reg;
    logic [63:0]         acc_reg, acc_next;
    logic [15:0]         mul_chunk;
    logic [79:0]         prod;

    logic [63:0]         quo_reg, rem_reg, dvs_reg;
    logic [5:0]          dcnt_reg;
    logic                dneg_reg, dzero_reg;
    logic [64:0]         rem_sh, rem_diff;
    logic                div_ge;
    logic [63:0]         quo_next, rem_next, div_res;
    logic                div_by_zero;

    logic                wr_en;
    logic [63:0]         wr_data;
    logic                out_load, last_step;
    eng_state_t          after_step;

    logic signed [31:0]  res_word;
    logic [15:0]         res_temp_reg;
    logic [31:0]         res_pres_reg;
    logic [16:0]         res_hum_reg;
    logic                out_valid_reg;
    logic [15:0]         out_temp_reg;
    logic [31:0]         out_pres_reg;
    logic [16:0]         out_hum_reg;
    logic                out_zero_reg;

    // Fixed operand values: inputs, unpacked coefficients, constants
    function automatic logic [63:0] fx_value(fx_src_t s, pscu_calib_t c, logic [19:0] ap,
                                             logic [19:0] at, logic [15:0] ah);
        logic [63:0] v;
        v = '0;
        case (s)
            FX_AT:       v = {44'd0, at};
            FX_AP:       v = {44'd0, ap};
            FX_AH:       v = {48'd0, ah};
            FX_T1:       v = {48'd0, c.tp_low[15:0]};
            FX_T2:       v = {{48{c.tp_low[31]}}, c.tp_low[31:16]};
            FX_T3:       v = {{48{c.tp_low[47]}}, c.tp_low[47:32]};
            FX_P1:       v = {48'd0, c.tp_low[63:48]};
            FX_P2:       v = {{48{c.tp_mid[15]}}, c.tp_mid[15:0]};
            FX_P3:       v = {{48{c.tp_mid[31]}}, c.tp_mid[31:16]};
            FX_P4:       v = {{48{c.tp_mid[47]}}, c.tp_mid[47:32]};
            FX_P5:       v = {{48{c.tp_mid[63]}}, c.tp_mid[63:48]};
            FX_P6:       v = {{48{c.tp_high[15]}}, c.tp_high[15:0]};
            FX_P7:       v = {{48{c.tp_high[31]}}, c.tp_high[31:16]};
            FX_P8:       v = {{48{c.tp_high[47]}}, c.tp_high[47:32]};
            FX_P9:       v = {{48{c.tp_high[63]}}, c.tp_high[63:48]};
            FX_H1:       v = {56'd0, c.hum_first};
            FX_H2:       v = {{48{c.hum_rest[15]}}, c.hum_rest[15:0]};
            FX_H3:       v = {56'd0, c.hum_rest[23:16]};
            FX_H4:       v = {{52{c.hum_rest[31]}}, c.hum_rest[31:24], c.hum_rest[35:32]};
            FX_H5:       v = {{52{c.hum_rest[47]}}, c.hum_rest[47:40], c.hum_rest[39:36]};
            FX_H6:       v = {{56{c.hum_rest[55]}}, c.hum_rest[55:48]};
            FX_C5:       v = 64'd5;
            FX_C128:     v = 64'd128;
            FX_C128000:  v = 64'd128000;
            FX_C2P20:    v = 64'd1048576;
            FX_C3125:    v = 64'd3125;
            FX_C2P47:    v = 64'h0000_8000_0000_0000;
            FX_C76800:   v = 64'd76800;
            FX_C16384:   v = 64'd16384;
            FX_C32768:   v = 64'd32768;
            FX_C2097152: v = 64'd2097152;
            FX_C8192:    v = 64'd8192;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] norm32(logic [63:0] v, logic w);
        return w ? {{32{v[31]}}, v[31:0]} : v;
    endfunction

    assign uop = uop_rom(pc_reg);

    // Select operands
    always_comb
    begin
        opa = uop.a_fx ? fx_value(fx_src_t'(uop.a_sel), calib, ap_reg, at_reg, ah_reg)
                       : rda_reg;
        opb = uop.b_fx ? fx_value(fx_src_t'(uop.b_sel), calib, ap_reg, at_reg, ah_reg)
                       : rdb_reg;
    end

    // Combinational ALU operations
    always_comb
    begin
        case (uop.kind)
            OP_ADD:  alu_raw = opa + opb;
            OP_SUB:  alu_raw = opa - opb;
            OP_SRA:  alu_raw = 64'($signed(opa) >>> uop.sh);
            OP_SHL:  alu_raw = opa << uop.sh;
            default: alu_raw = opa;
        endcase
        alu_res = norm32(alu_raw, uop.w32);
    end

    // Multiply one 16-bit slice of operand b per cycle
    assign mul_chunk = opb[{mk_reg, 4'd0} +: 16];
    assign prod      = opa * mul_chunk;
    assign acc_next  = acc_reg + (prod[63:0] << {mk_reg, 4'd0});

    // One restoring division step on magnitudes
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[63]};
        rem_diff = rem_sh - {1'b0, dvs_reg};
        div_ge   = (rem_sh >= {1'b0, dvs_reg});
        rem_next = div_ge ? rem_diff[63:0] : rem_sh[63:0];
        quo_next = {quo_reg[62:0], div_ge};
        div_res  = dneg_reg ? (64'd0 - quo_next) : quo_next;
    end

    assign div_by_zero = (opb == '0);
    assign last_step   = (pc_reg == PC_W'(UOP_COUNT - 1));
    assign after_step  = last_step ? ST_DONE : ST_READ;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (deq.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (uop.kind == OP_MUL)
                begin
                    state_next = ST_MUL;
                end
                else if (uop.kind == OP_DIV && !div_by_zero)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = after_step;
                end
            end
            ST_MUL:
            begin
                if (mk_reg == 2'(MUL_CHUNKS - 1))
                begin
                    state_next = after_step;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = after_step;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs: every step ends with exactly one scratch write
    always_comb
    begin
        wr_en     = 1'b0;
        wr_data   = alu_res;
        deq_ready = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                deq_ready = 1'b1;
            end
            ST_READ:
            begin
                wr_en = 1'b0;
            end
            ST_EXEC:
            begin
                if (uop.kind == OP_DIV)
                begin
                    wr_en   = div_by_zero;
                    wr_data = '0;
                end
                else if (uop.kind != OP_MUL)
                begin
                    wr_en = 1'b1;
                end
            end
            ST_MUL:
            begin
                wr_en   = (mk_reg == 2'(MUL_CHUNKS - 1));
                wr_data = norm32(acc_next, uop.w32);
            end
            ST_DIV:
            begin
                wr_en   = (dcnt_reg == 6'(DIV_STEPS - 1));
                wr_data = div_res;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            mk_reg        <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                pc_reg <= '0;
            end
            else if (wr_en && !last_step)
            begin
                pc_reg <= pc_reg + PC_W'(1);
            end
            if (state_reg == ST_EXEC)
            begin
                mk_reg   <= '0;
                dcnt_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_MUL)
                begin
                    mk_reg <= mk_reg + 2'd1;
                end
                if (state_reg == ST_DIV)
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Scratch memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tmp_mem[uop.dst] <= wr_data;
        end
        if (state_reg == ST_READ)
        begin
            rda_reg <= tmp_mem[uop.a_sel[TMP_AW-1:0]];
            rdb_reg <= tmp_mem[uop.b_sel[TMP_AW-1:0]];
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && deq.valid)
        begin
            ap_reg    <= deq.item.raw_pressure;
            at_reg    <= deq.item.raw_temperature;
            ah_reg    <= deq.item.raw_humidity;
            dzero_reg <= 1'b0;
        end
        if (state_reg == ST_EXEC)
        begin
            acc_reg  <= '0;
            quo_reg  <= opa[63] ? (64'd0 - opa) : opa;
            dvs_reg  <= opb[63] ? (64'd0 - opb) : opb;
            rem_reg  <= '0;
            dneg_reg <= opa[63] ^ opb[63];
            if (uop.kind == OP_DIV && div_by_zero)
            begin
                dzero_reg <= 1'b1;
            end
        end
        if (state_reg == ST_MUL)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Capture the output fields as their final steps complete
    assign res_word = wr_data[31:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && pc_reg == UPC_TEMP)
        begin
            if (res_word > TEMP_MAX)
            begin
                res_temp_reg <= TEMP_MAX[15:0];
            end
            else if (res_word < TEMP_MIN)
            begin
                res_temp_reg <= TEMP_MIN[15:0];
            end
            else
            begin
                res_temp_reg <= res_word[15:0];
            end
        end
        if (wr_en && pc_reg == UPC_PRES)
        begin
            res_pres_reg <= dzero_reg ? 32'd0 : wr_data[31:0];
        end
        if (wr_en && pc_reg == UPC_HUM)
        begin
            if (res_word < 0)
            begin
                res_hum_reg <= '0;
            end
            else if (res_word > HUM_MAX)
            begin
                res_hum_reg <= HUM_MAX[28:12];
            end
            else
            begin
                res_hum_reg <= res_word[28:12];
            end
        end
        if (out_load)
        begin
            out_temp_reg <= res_temp_reg;
            out_pres_reg <= res_pres_reg;
            out_hum_reg  <= res_hum_reg;
            out_zero_reg <= dzero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_hum_reg, out_pres_reg, out_temp_reg};
    assign m_tuser  = out_zero_reg;

    `PSCU_ASSERT_NEVER(a_pc_range, (state_reg != ST_IDLE) && (pc_reg >= PC_W'(UOP_COUNT)))
    `PSCU_ASSERT(a_hold_done, (state_reg == ST_DONE && out_valid_reg && !m_tready) |=> (state_reg == ST_DONE))
    `PSCU_ASSERT(a_dzero_src, $rose(dzero_reg) |-> $past(state_reg == ST_EXEC && uop.kind == OP_DIV))

endmodule

[design/pth_sensor_compensation_unit.sv]
// Compensation unit: each sample set is processed by the microcoded engine, one
// step at a time (a read and an execute state per step, extra states for the
// chunked 64-bit multiply and the divide, plus idle and hand-off states); the
// divide is skipped when the pressure divisor is zero.
// A four-entry queue accepts new samples while the engine is busy.
// rst_n clears all control state and the calibration registers to zero.
module pth_sensor_compensation_unit #(
    parameter int QUEUE_DEPTH = pscu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] temperature_centi, [47:16] pressure_q24_8, [64:48] humidity_q22_10
    output logic [71:0] m_tdata,
    // [0] pressure_divisor_zero
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import pscu_pkg::*;

    pscu_calib_t calib_reg;
    pscu_deq_t   deq;
    logic        deq_ready;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    // Calibration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TP_LOW:    calib_reg.tp_low    <= pwdata;
                REG_TP_MID:    calib_reg.tp_mid    <= pwdata;
                REG_TP_HIGH:   calib_reg.tp_high   <= pwdata;
                REG_HUM_FIRST: calib_reg.hum_first <= pwdata[7:0];
                REG_HUM_REST:  calib_reg.hum_rest  <= pwdata[55:0];
                default:       calib_reg           <= calib_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_TP_LOW:    prdata = calib_reg.tp_low;
            REG_TP_MID:    prdata = calib_reg.tp_mid;
            REG_TP_HIGH:   prdata = calib_reg.tp_high;
            REG_HUM_FIRST: prdata = {56'd0, calib_reg.hum_first};
            REG_HUM_REST:  prdata = {8'd0, calib_reg.hum_rest};
            default:       prdata = '0;
        endcase
    end

    pscu_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .deq       (deq),
        .deq_ready (deq_ready)
    );

    pscu_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .calib     (calib_reg),
        .deq       (deq),
        .deq_ready (deq_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
